@@ rtl/core/nna_pkg.sv @@
package nna_pkg;

    localparam int DATA_WIDTH      = 32;
    localparam int FRAC_BITS       = 16;
    localparam int EXP_TABLE_DEPTH = 256;
    localparam int IDX_BITS        = $clog2(EXP_TABLE_DEPTH);
    localparam int SLOPE_WIDTH     = 19;
    localparam int QUOT_BITS       = FRAC_BITS + 1;
    localparam int WIDE_WIDTH      = 68;

    localparam logic [3:0] MODE_SIGMOID   = 4'd0;
    localparam logic [3:0] MODE_RELU      = 4'd1;
    localparam logic [3:0] MODE_LEAKY     = 4'd2;
    localparam logic [3:0] MODE_ELU       = 4'd3;
    localparam logic [3:0] MODE_D_SIGMOID = 4'd4;
    localparam logic [3:0] MODE_D_RELU    = 4'd5;
    localparam logic [3:0] MODE_D_LEAKY   = 4'd6;
    localparam logic [3:0] MODE_D_ELU     = 4'd7;

    localparam logic [SLOPE_WIDTH-1:0] SLOPE_RESET = 19'd655;
    localparam logic signed [31:0] LOG2E_Q30 = 32'sd1549082005;

    typedef logic [30:0] exp_entry_t;
    typedef exp_entry_t exp_table_t [EXP_TABLE_DEPTH];

    // Builds the table of 2^(i/D) in Q30 from the twelve binary roots of two.
    function automatic exp_table_t build_exp_table();
        longint unsigned roots [12];
        longint unsigned acc;
        longint unsigned xi;
        exp_table_t tab;
        roots[0]  = 64'd1518500250;
        roots[1]  = 64'd1276901417;
        roots[2]  = 64'd1170923762;
        roots[3]  = 64'd1121280437;
        roots[4]  = 64'd1097253708;
        roots[5]  = 64'd1085434105;
        roots[6]  = 64'd1079572136;
        roots[7]  = 64'd1076653033;
        roots[8]  = 64'd1075196442;
        roots[9]  = 64'd1074468887;
        roots[10] = 64'd1074105294;
        roots[11] = 64'd1073923544;
        for (int i = 0; i < EXP_TABLE_DEPTH; i++)
        begin
            xi  = (64'(i) * 64'd4096) / EXP_TABLE_DEPTH;
            acc = 64'd1 << 30;
            for (int m = 0; m < 12; m++)
            begin
                if (((xi >> (11 - m)) & 64'd1) != 64'd0)
                begin
                    acc = (acc * roots[m]) >> 30;
                end
            end
            tab[i] = acc[30:0];
        end
        return tab;
    endfunction

    localparam exp_table_t EXP_TABLE = build_exp_table();

    // Saturates a wide signed value to the signed output range.
    function automatic logic signed [DATA_WIDTH-1:0] sat_out(
        input logic signed [WIDE_WIDTH-1:0] v
    );
        logic signed [WIDE_WIDTH-1:0] hi;
        logic signed [WIDE_WIDTH-1:0] lo;
        hi = (WIDE_WIDTH'(1) <<< (DATA_WIDTH - 1)) - WIDE_WIDTH'(1);
        lo = -hi - WIDE_WIDTH'(1);
        if (v > hi)
        begin
            return hi[DATA_WIDTH-1:0];
        end
        else if (v < lo)
        begin
            return lo[DATA_WIDTH-1:0];
        end
        return v[DATA_WIDTH-1:0];
    endfunction

endpackage

@@ rtl/core/nn_activation_unit.sv @@
// Element-wise activation unit, signed Q16.16.
// Throughput: one element per cycle; busy is always low. The core is a 17-stage
// pipelined restoring divider behind a five-stage exponent front end.
// Reset: rst_n clears all valid bits and loads the slope with 0.01.
// The receiver cannot stall; each result is shown for one cycle.
module nn_activation_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [3:0]                           mode,
    input  logic signed [nna_pkg::DATA_WIDTH-1:0] value,
    input  logic                                 last,
    input  logic                                 cfg_we,
    input  logic [nna_pkg::SLOPE_WIDTH-1:0]      cfg_data,
    output logic                                 done,
    output logic signed [nna_pkg::DATA_WIDTH-1:0] result,
    output logic                                 last_out
);
    import nna_pkg::*;

    localparam int DV_STAGES = QUOT_BITS;
    localparam logic signed [34:0] ONE_35 = 35'sd1 <<< FRAC_BITS;

    logic [SLOPE_WIDTH-1:0] slope_reg;

    // Stage 0: input register.
    logic                         s0_valid_reg;
    logic [3:0]                   s0_mode_reg;
    logic signed [DATA_WIDTH-1:0] s0_x_reg;
    logic                         s0_last_reg;

    // Stage 1: exponent multiply and the general product.
    logic                         s1_valid_reg;
    logic [3:0]                   s1_mode_reg;
    logic signed [DATA_WIDTH-1:0] s1_x_reg;
    logic                         s1_last_reg;
    logic signed [64:0]           s1_lp_reg;
    logic signed [67:0]           s1_pa_reg;
    logic signed [32:0]           s1_t_next;
    logic signed [33:0]           s1_a_next;
    logic signed [33:0]           s1_b_next;

    // Stage 2: table lookup.
    logic                         s2_valid_reg;
    logic [3:0]                   s2_mode_reg;
    logic signed [DATA_WIDTH-1:0] s2_x_reg;
    logic                         s2_last_reg;
    logic signed [67:0]           s2_pa_reg;
    logic [30:0]                  s2_m_reg;
    logic signed [18:0]           s2_k_reg;
    logic [34:0]                  s2_u_next;

    // Stage 3: scale by 2^k.
    logic                         s3_valid_reg;
    logic [3:0]                   s3_mode_reg;
    logic signed [DATA_WIDTH-1:0] s3_x_reg;
    logic                         s3_last_reg;
    logic signed [67:0]           s3_pa_reg;
    logic [33:0]                  s3_e_reg;
    logic                         s3_over_reg;
    logic [33:0]                  s3_e_next;
    logic signed [18:0]           s3_rsh;
    logic signed [18:0]           s3_lsh;

    // Stage 4: ELU product and divisor.
    logic                         s4_valid_reg;
    logic [3:0]                   s4_mode_reg;
    logic signed [DATA_WIDTH-1:0] s4_x_reg;
    logic                         s4_last_reg;
    logic signed [67:0]           s4_pa_reg;
    logic signed [54:0]           s4_elu_reg;
    logic [34:0]                  s4_den_reg;
    logic                         s4_over_reg;
    logic signed [34:0]           s4_em1;

    // Divider pipeline, with the non-sigmoid result carried alongside.
    logic                         dv_valid_reg [DV_STAGES+1];
    logic                         dv_last_reg  [DV_STAGES+1];
    logic                         dv_sig_reg   [DV_STAGES+1];
    logic                         dv_over_reg  [DV_STAGES+1];
    logic signed [DATA_WIDTH-1:0] dv_alt_reg   [DV_STAGES+1];
    logic [32:0]                  dv_rem_reg   [DV_STAGES+1];
    logic [34:0]                  dv_den_reg   [DV_STAGES+1];
    logic [QUOT_BITS-1:0]         dv_q_reg     [DV_STAGES+1];
    logic signed [DATA_WIDTH-1:0] alt_next;

    // Output register.
    logic                         done_reg;
    logic signed [DATA_WIDTH-1:0] result_reg;
    logic                         last_out_reg;
    logic signed [DATA_WIDTH-1:0] result_next;

    assign busy     = 1'b0;
    assign done     = done_reg;
    assign result   = result_reg;
    assign last_out = last_out_reg;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slope_reg <= SLOPE_RESET;
        end
        else if (cfg_we)
        begin
            slope_reg <= cfg_data;
        end
    end

    // Valid bits of the front end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= start;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // Stage 1 operand selection: the exponent argument and the product pair.
    always_comb
    begin
        if (s0_mode_reg == MODE_SIGMOID)
        begin
            s1_t_next = -33'(s0_x_reg);
        end
        else
        begin
            s1_t_next = 33'(s0_x_reg);
        end
        s1_a_next = 34'(s0_x_reg);
        if (s0_mode_reg == MODE_D_SIGMOID)
        begin
            s1_b_next = ONE_35[33:0] - 34'(s0_x_reg);
        end
        else
        begin
            s1_b_next = signed'({15'd0, slope_reg});
        end
    end

    // Stage 2 decode of the base-2 exponent.
    assign s2_u_next = s1_lp_reg[64:30];

    // Stage 3 shift amounts.
    assign s3_rsh = 19'sd14 - s2_k_reg;
    assign s3_lsh = s2_k_reg - 19'sd14;

    always_comb
    begin
        if (s2_k_reg < -19'sd48)
        begin
            s3_e_next = '0;
        end
        else if (s2_k_reg <= 19'sd14)
        begin
            s3_e_next = {3'd0, s2_m_reg} >> s3_rsh[5:0];
        end
        else
        begin
            s3_e_next = {3'd0, s2_m_reg} << s3_lsh[1:0];
        end
    end

    // Stage 4: exp(x) - 1 in Q16.16.
    assign s4_em1 = signed'({1'b0, s3_e_reg}) - ONE_35;

    // Front-end data path.
    always_ff @(posedge clk)
    begin
        s0_mode_reg <= mode;
        s0_x_reg    <= value;
        s0_last_reg <= last;

        s1_mode_reg <= s0_mode_reg;
        s1_x_reg    <= s0_x_reg;
        s1_last_reg <= s0_last_reg;
        s1_lp_reg   <= 65'(s1_t_next) * 65'(LOG2E_Q30);
        s1_pa_reg   <= 68'(s1_a_next) * 68'(s1_b_next);

        s2_mode_reg <= s1_mode_reg;
        s2_x_reg    <= s1_x_reg;
        s2_last_reg <= s1_last_reg;
        s2_pa_reg   <= s1_pa_reg;
        s2_m_reg    <= EXP_TABLE[s2_u_next[FRAC_BITS-1 -: IDX_BITS]];
        s2_k_reg    <= signed'(s2_u_next[34:FRAC_BITS]);

        s3_mode_reg <= s2_mode_reg;
        s3_x_reg    <= s2_x_reg;
        s3_last_reg <= s2_last_reg;
        s3_pa_reg   <= s2_pa_reg;
        s3_e_reg    <= s3_e_next;
        s3_over_reg <= (s2_k_reg > 19'sd16);

        s4_mode_reg <= s3_mode_reg;
        s4_x_reg    <= s3_x_reg;
        s4_last_reg <= s3_last_reg;
        s4_pa_reg   <= s3_pa_reg;
        s4_elu_reg  <= 55'(s4_em1) * 55'(signed'({1'b0, slope_reg}));
        s4_den_reg  <= 35'(ONE_35) + {1'b0, s3_e_reg};
        s4_over_reg <= s3_over_reg;
    end

    // Result of every mode but sigmoid.
    always_comb
    begin
        case (s4_mode_reg)
            MODE_RELU:
            begin
                alt_next = s4_x_reg[DATA_WIDTH-1] ? '0 : s4_x_reg;
            end
            MODE_LEAKY:
            begin
                alt_next = s4_x_reg[DATA_WIDTH-1] ? sat_out(s4_pa_reg >>> FRAC_BITS)
                                                   : s4_x_reg;
            end
            MODE_ELU:
            begin
                alt_next = s4_x_reg[DATA_WIDTH-1]
                         ? sat_out(68'(s4_elu_reg >>> FRAC_BITS)) : s4_x_reg;
            end
            MODE_D_SIGMOID:
            begin
                alt_next = sat_out(s4_pa_reg >>> FRAC_BITS);
            end
            MODE_D_RELU:
            begin
                alt_next = s4_x_reg[DATA_WIDTH-1] ? '0 : 32'(ONE_35);
            end
            MODE_D_LEAKY:
            begin
                alt_next = s4_x_reg[DATA_WIDTH-1] ? 32'({1'b0, slope_reg})
                                                   : 32'(ONE_35);
            end
            MODE_D_ELU:
            begin
                alt_next = s4_x_reg[DATA_WIDTH-1]
                         ? sat_out(68'(s4_x_reg) + 68'({1'b0, slope_reg}))
                         : 32'(ONE_35);
            end
            default:
            begin
                alt_next = s4_x_reg;
            end
        endcase
    end

    // Divider entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg[0] <= 1'b0;
        end
        else
        begin
            dv_valid_reg[0] <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dv_last_reg[0] <= s4_last_reg;
        dv_sig_reg[0]  <= (s4_mode_reg == MODE_SIGMOID);
        dv_over_reg[0] <= s4_over_reg;
        dv_alt_reg[0]  <= alt_next;
        dv_rem_reg[0]  <= 33'd1 << (2 * FRAC_BITS);
        dv_den_reg[0]  <= s4_den_reg;
        dv_q_reg[0]    <= '0;
    end

    // One quotient bit per stage, most significant first.
    for (genvar j = 0; j < DV_STAGES; j++)
    begin : g_div
        localparam int BIT = QUOT_BITS - 1 - j;
        logic [51:0] shifted;
        logic        fits;

        assign shifted = 52'(dv_den_reg[j]) << BIT;
        assign fits    = 52'(dv_rem_reg[j]) >= shifted;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[j+1] <= 1'b0;
            end
            else
            begin
                dv_valid_reg[j+1] <= dv_valid_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            dv_last_reg[j+1] <= dv_last_reg[j];
            dv_sig_reg[j+1]  <= dv_sig_reg[j];
            dv_over_reg[j+1] <= dv_over_reg[j];
            dv_alt_reg[j+1]  <= dv_alt_reg[j];
            dv_den_reg[j+1]  <= dv_den_reg[j];
            if (fits)
            begin
                dv_rem_reg[j+1] <= dv_rem_reg[j] - shifted[32:0];
                dv_q_reg[j+1]   <= dv_q_reg[j] | (QUOT_BITS'(1) << BIT);
            end
            else
            begin
                dv_rem_reg[j+1] <= dv_rem_reg[j];
                dv_q_reg[j+1]   <= dv_q_reg[j];
            end
        end
    end

    // Final selection with the sigmoid clamp.
    always_comb
    begin
        if (!dv_sig_reg[DV_STAGES])
        begin
            result_next = dv_alt_reg[DV_STAGES];
        end
        else if (dv_over_reg[DV_STAGES] || (dv_q_reg[DV_STAGES] == '0))
        begin
            result_next = 32'sd1;
        end
        else if (dv_q_reg[DV_STAGES][QUOT_BITS-1])
        begin
            result_next = 32'(ONE_35) - 32'sd1;
        end
        else
        begin
            result_next = 32'(dv_q_reg[DV_STAGES]);
        end
    end

    // Output register and strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_valid_reg[DV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg   <= result_next;
        last_out_reg <= dv_last_reg[DV_STAGES];
    end

endmodule

@@ dv/nna_checker.sv @@
`timescale 1ns / 100ps

module nna_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic                                  busy,
    input  logic [3:0]                            mode,
    input  logic signed [nna_pkg::DATA_WIDTH-1:0] value,
    input  logic                                  last,
    input  logic                                  cfg_we,
    input  logic [nna_pkg::SLOPE_WIDTH-1:0]       cfg_data,
    input  logic                                  done,
    input  logic signed [nna_pkg::DATA_WIDTH-1:0] result,
    input  logic                                  last_out,
    output int                                    fail_count,
    output int                                    pending
);

    import nna_pkg::*;

    localparam longint Q_ONE   = 64'sd1 << FRAC_BITS;
    localparam longint LOG2E   = 64'sd1549082005;
    localparam longint SAT_HI  = (64'sd1 << (DATA_WIDTH - 1)) - 1;
    localparam longint SAT_LO  = -SAT_HI - 1;

    typedef struct {
        logic signed [DATA_WIDTH-1:0] res;
        logic                         lst;
    } act_result_t;

    act_result_t                 act_queue [$];
    logic [SLOPE_WIDTH-1:0]      slope_q;

    // Root factors 2^(2^-(m+1)) in Q30.
    function automatic longint unsigned root_q30(input int m);
        case (m)
            0:  return 64'd1518500250;
            1:  return 64'd1276901417;
            2:  return 64'd1170923762;
            3:  return 64'd1121280437;
            4:  return 64'd1097253708;
            5:  return 64'd1085434105;
            6:  return 64'd1079572136;
            7:  return 64'd1076653033;
            8:  return 64'd1075196442;
            9:  return 64'd1074468887;
            10: return 64'd1074105294;
            default: return 64'd1073923544;
        endcase
    endfunction

    // 2^(idx/D) in Q30 as a truncated product of root factors.
    function automatic longint unsigned pow2_q30(input longint unsigned idx);
        longint unsigned sel;
        longint unsigned acc;
        sel = (idx * 64'd4096) / EXP_TABLE_DEPTH;
        acc = 64'd1 << 30;
        for (int m = 0; m < 12; m++)
        begin
            if (sel[11 - m])
            begin
                acc = (acc * root_q30(m)) >> 30;
            end
        end
        return acc;
    endfunction

    // exp(t) in Q16.16; huge is set when the base-2 exponent exceeds FRAC_BITS.
    function automatic longint exp_q16(input longint t, output bit huge);
        longint          u;
        longint          k;
        longint          s;
        longint unsigned frac;
        longint unsigned mant;
        u    = (t * LOG2E) >>> 30;
        k    = u >>> FRAC_BITS;
        frac = longint'(u) & ((64'd1 << FRAC_BITS) - 1);
        huge = (k > FRAC_BITS);
        if (huge)
        begin
            return 0;
        end
        mant = pow2_q30((frac * EXP_TABLE_DEPTH) >> FRAC_BITS);
        s    = 30 - FRAC_BITS - k;
        if (s >= 63)
        begin
            return 0;
        end
        if (s >= 0)
        begin
            return longint'(mant >> s);
        end
        return longint'(mant << (-s));
    endfunction

    // Expected activation output for one element.
    function automatic logic signed [DATA_WIDTH-1:0] activation_expect(
        input logic [3:0]                   md,
        input logic signed [DATA_WIDTH-1:0] v,
        input logic [SLOPE_WIDTH-1:0]       slp
    );
        longint x;
        longint sl;
        longint r;
        longint e;
        bit     huge;
        x  = longint'(v);
        sl = longint'({45'd0, slp});
        case (md)
            MODE_SIGMOID:
            begin
                e = exp_q16(-x, huge);
                if (huge)
                begin
                    r = 1;
                end
                else
                begin
                    r = longint'((64'd1 << (2 * FRAC_BITS)) / longint'(Q_ONE + e));
                    if (r < 1) r = 1;
                    if (r > Q_ONE - 1) r = Q_ONE - 1;
                end
            end
            MODE_RELU:      r = (x >= 0) ? x : 0;
            MODE_LEAKY:     r = (x >= 0) ? x : ((sl * x) >>> FRAC_BITS);
            MODE_ELU:
            begin
                e = exp_q16(x, huge);
                r = (x >= 0) ? x : ((sl * (e - Q_ONE)) >>> FRAC_BITS);
            end
            MODE_D_SIGMOID: r = (x * (Q_ONE - x)) >>> FRAC_BITS;
            MODE_D_RELU:    r = (x >= 0) ? Q_ONE : 0;
            MODE_D_LEAKY:   r = (x >= 0) ? Q_ONE : sl;
            MODE_D_ELU:     r = (x >= 0) ? Q_ONE : x + sl;
            default:        r = x;
        endcase
        if (r > SAT_HI) r = SAT_HI;
        if (r < SAT_LO) r = SAT_LO;
        return r[DATA_WIDTH-1:0];
    endfunction

    // Track the slope register as the block sees it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slope_q <= SLOPE_RESET;
        end
        else if (cfg_we)
        begin
            slope_q <= cfg_data;
        end
    end

    // Predict on each input transfer and compare each result transfer.
    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge clk)
    begin
        act_result_t exp_r;
        act_result_t got;
        if (rst_n)
        begin
            if (done)
            begin
                if (act_queue.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, result);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    exp_r = act_queue.pop_front();
                    if (result !== exp_r.res)
                    begin
                        $display("%0t: result expected %h actual %h",
                                 $time, exp_r.res, result);
                        fail_count = fail_count + 1;
                    end
                    if (last_out !== exp_r.lst)
                    begin
                        $display("%0t: last_out expected %b actual %b",
                                 $time, exp_r.lst, last_out);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (start && !busy)
            begin
                got.res = activation_expect(mode, value, slope_q);
                got.lst = last;
                act_queue.push_back(got);
            end
            pending = act_queue.size();
        end
    end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    import nna_pkg::*;

    localparam int     CYCLE_LIMIT = 200000;
    localparam int     DRAIN       = 40;
    localparam longint Q_ONE       = 64'sd1 << FRAC_BITS;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic [3:0]                   mode;
    logic signed [DATA_WIDTH-1:0] value;
    logic                         last;
    logic                         cfg_we;
    logic [SLOPE_WIDTH-1:0]       cfg_data;
    logic                         done;
    logic signed [DATA_WIDTH-1:0] result;
    logic                         last_out;
    int                           fail_count;
    int                           pending;
    int                           cycles;

    nn_activation_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .mode     (mode),
        .value    (value),
        .last     (last),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .done     (done),
        .result   (result),
        .last_out (last_out)
    );

    nna_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .value      (value),
        .last       (last),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .done       (done),
        .result     (result),
        .last_out   (last_out),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog on the total run length.
    initial
    begin
        cycles = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL nn_activation_unit");
            $finish;
        end
    end

    // One element transfer; called right after a rising edge.
    task automatic send_element(input logic [3:0] md, input logic [31:0] v, input logic lst);
        start <= 1'b1;
        mode  <= md;
        value <= v;
        last  <= lst;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Drain all outstanding results, let the pipe empty, then load the slope.
    task automatic load_slope(input logic [SLOPE_WIDTH-1:0] s);
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= s;
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_value(input logic [3:0] md);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 3)
        begin
            return $urandom;
        end
        else if (pick < 7)
        begin
            return 32'($signed($urandom_range(0, 24 * Q_ONE)) - 12 * Q_ONE);
        end
        else if (md == MODE_D_SIGMOID || pick == 7)
        begin
            return 32'($urandom_range(0, Q_ONE));
        end
        return 32'($signed($urandom_range(0, 2 * Q_ONE)) - 2 * Q_ONE);
    endfunction

    // Random traffic in bursts with gaps of random length.
    task automatic random_traffic(input int count);
        int          left;
        int          burst;
        logic [3:0]  md;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 24);
            if (burst > left) burst = left;
            repeat (burst)
            begin
                md = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(8, 15))
                                                 : 4'($urandom_range(0, 7));
                send_element(md, rand_value(md), 1'($urandom));
            end
            left = left - burst;
            if ($urandom_range(0, 3) != 0)
            begin
                idle_cycles($urandom_range(1, 8));
            end
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        logic [31:0] corner [6];
        start    = 1'b0;
        mode     = '0;
        value    = '0;
        last     = 1'b0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        rst_n    = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every mode code, each against one of the value extremes, at the reset slope.
        corner[0] = 32'h8000_0000;
        corner[1] = 32'h7FFF_FFFF;
        corner[2] = 32'h0000_0000;
        corner[3] = 32'hFFFF_FFFF;
        corner[4] = 32'h0001_0000;
        corner[5] = 32'hFFFF_0000;
        for (int m = 0; m < 16; m++)
        begin
            send_element(4'(m), corner[m % 6], 1'(m % 2));
        end
        send_element(MODE_SIGMOID, 32'h0020_0000, 1'b0);
        send_element(MODE_SIGMOID, 32'hFFE0_0000, 1'b1);
        send_element(MODE_D_SIGMOID, 32'h8000_0000, 1'b0);
        send_element(MODE_LEAKY, 32'h8000_0000, 1'b1);
        send_element(MODE_ELU, 32'hFFF0_0000, 1'b0);
        send_element(MODE_D_ELU, 32'h8000_0000, 1'b1);
        random_traffic(140);

        // Zero slope, a slope of 4.0, the top of the 19-bit field and a random one.
        load_slope('0);
        random_traffic(160);
        load_slope(19'd262144);
        random_traffic(160);
        load_slope('1);
        send_element(MODE_LEAKY, 32'h8000_0000, 1'b0);
        send_element(MODE_D_ELU, 32'hFFFF_FFFF, 1'b1);
        random_traffic(160);
        load_slope(19'($urandom));
        random_traffic(160);

        // Wait for the last results, then let the pipe settle.
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("PASS nn_activation_unit");
        end
        else
        begin
            $display("FAIL nn_activation_unit");
        end
        $finish;
    end

endmodule
